@@ design/plvm_pkg.sv @@
// ----------------------------------------------------------------------------
// plvm_pkg
// Shared types and constants of the peak level volume modifier: controller
// states, command and status groups, and the result item.
// ----------------------------------------------------------------------------
package plvm_pkg;

   localparam int GAIN_W      = 16;
   localparam int PEAK_OUT_W  = 16;
   localparam int MOD_W       = 8;
   localparam int F_W         = 19;
   localparam int M_W         = 32;
   localparam int NORM_PAD    = M_W - F_W;
   localparam int SHIFT_W     = 4;

   localparam logic [GAIN_W-1:0]  GAIN_ONE = 16'd4096;
   localparam logic [F_W-1:0]     F_MIN    = 19'd1024;
   localparam logic [F_W-1:0]     F_MAX    = 19'd262144;
   // exponent of F's top bit relative to the Q.12 point, and the lowest one
   localparam logic [SHIFT_W-1:0] EXP_TOP  = 4'd6;
   localparam logic [SHIFT_W-1:0] EXP_LOW  = 4'b1110;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_NORMALIZE,
      ST_LOG,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic second;
      logic div_load;
      logic div_step;
      logic norm_load;
      logic norm_step;
      logic log_load;
      logic log_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic peak_zero;
      logic div_done;
      logic norm_done;
      logic log_done;
      logic two_jobs;
   } dp_status_type;

   typedef struct packed {
      logic [PEAK_OUT_W-1:0] peak_level;
      logic [MOD_W-1:0]      volume_modifier;
      logic                  has_level;
      logic                  clip_seen;
      logic                  is_album;
      logic                  last_result;
   } result_type;

endpackage

@@ design/plvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// plvm_ctrl
// Sequencer: takes samples, then steps the datapath through divide, normalize
// and log (none for a zero peak) for the track and, when asked, album result.
// ----------------------------------------------------------------------------
module plvm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_track_end,
   output logic                   req_ready,
   input  logic                   out_free,
   input  plvm_pkg::dp_status_type status,
   output plvm_pkg::ctrl_cmd_type  cmd
);
   import plvm_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.second = second_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_track_end) begin
               second_in = 1'b0;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.peak_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.norm_load = 1'b1;
               state_in      = ST_NORMALIZE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_NORMALIZE: begin
            if (status.norm_done) begin
               cmd.log_load = 1'b1;
               state_in     = ST_LOG;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_LOG: begin
            if (status.log_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.log_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (!second_ff && status.two_jobs) begin
                  second_in = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  second_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/plvm_datapath.sv @@
// ----------------------------------------------------------------------------
// plvm_datapath
// Peak tracking, gain register, restoring divider, leading-one normalizer
// and squaring log2 unit that form one result item.
// ----------------------------------------------------------------------------
module plvm_datapath #(
   parameter int SAMPLE_BITS       = 16,
   parameter int LOG_FRACTION_BITS = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plvm_pkg::ctrl_cmd_type        cmd,
   output plvm_pkg::dp_status_type       status,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          track_end,
   input  logic                          album_end,
   input  logic                          csr_write_enable,
   input  logic [plvm_pkg::GAIN_W-1:0]   csr_write_data,
   output plvm_pkg::result_type          result
);
   import plvm_pkg::*;

   localparam int QUOT_W = GAIN_W + SAMPLE_BITS - 1;
   localparam int DCNT_W = $clog2(QUOT_W + 1);
   localparam int LCNT_W = $clog2(LOG_FRACTION_BITS + 1);
   localparam int RES_W  = (LOG_FRACTION_BITS + SHIFT_W > MOD_W) ?
                           LOG_FRACTION_BITS + SHIFT_W : MOD_W;
   localparam logic [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] POS_FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic [GAIN_W-1:0]      gain_ff;
   logic [SAMPLE_BITS-1:0] track_peak_ff;
   logic [SAMPLE_BITS-1:0] album_peak_ff;
   logic                   clip_ff;
   logic                   two_jobs_ff;
   logic [SAMPLE_BITS-1:0] job1_peak_ff;
   logic                   job1_clip_ff;
   logic [SAMPLE_BITS-1:0] job2_peak_ff;

   logic [QUOT_W-1:0]      quot_ff;
   logic [SAMPLE_BITS-1:0] rem_ff;
   logic [DCNT_W-1:0]      div_cnt_ff;
   logic [F_W-1:0]         f_ff;
   logic [SHIFT_W-1:0]     shift_ff;
   logic [M_W-1:0]         m_ff;
   logic [LOG_FRACTION_BITS-1:0] frac_ff;
   logic [LCNT_W-1:0]      log_cnt_ff;

   logic [SAMPLE_BITS-1:0] sample_bits;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   raise;
   logic [SAMPLE_BITS-1:0] peak_new;
   logic                   clip_new;
   logic [SAMPLE_BITS-1:0] album_new;

   logic [SAMPLE_BITS-1:0] cur_peak;
   logic [GAIN_W-1:0]      gain_eff;
   logic [QUOT_W-1:0]      numerator;
   logic [SAMPLE_BITS:0]   rem_shift;
   logic                   fits;
   logic [SAMPLE_BITS:0]   rem_next;
   logic [F_W-1:0]         f_clamped;
   logic [2*M_W-1:0]       square;

   logic [SHIFT_W-1:0]           exp_rel;
   logic [LOG_FRACTION_BITS-1:0] frac_adj;
   logic signed [LOG_FRACTION_BITS+SHIFT_W-1:0] res;
   logic signed [RES_W-1:0]      res_ext;

   // sample tracking
   assign sample_bits = sample;
   assign mag         = sample_bits[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_bits + 1'b1)
                                                   : sample_bits;
   assign raise       = !clip_ff && (mag > track_peak_ff);
   assign peak_new    = raise ? mag : track_peak_ff;
   assign clip_new    = clip_ff | (raise && (sample_bits == NEG_FULL ||
                                             sample_bits == POS_FULL));
   assign album_new   = (peak_new > album_peak_ff) ? peak_new : album_peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= GAIN_ONE;
         track_peak_ff <= '0;
         album_peak_ff <= '0;
         clip_ff       <= 1'b0;
         two_jobs_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            gain_ff <= csr_write_data;
         end
         if (cmd.accept) begin
            if (track_end) begin
               track_peak_ff <= '0;
               clip_ff       <= 1'b0;
               two_jobs_ff   <= album_end;
               album_peak_ff <= album_end ? '0 : album_new;
            end else begin
               track_peak_ff <= peak_new;
               clip_ff       <= clip_new;
            end
         end
      end
   end

   // hold the peaks of the pending results
   always_ff @(posedge clock) begin
      if (cmd.accept && track_end) begin
         job1_peak_ff <= peak_new;
         job1_clip_ff <= clip_new;
         job2_peak_ff <= album_new;
      end
   end

   assign cur_peak  = cmd.second ? job2_peak_ff : job1_peak_ff;
   assign gain_eff  = (gain_ff == '0) ? GAIN_ONE : gain_ff;
   assign numerator = {gain_eff, {(SAMPLE_BITS-1){1'b0}}};

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quot_ff[QUOT_W-1]};
   assign fits      = rem_shift >= {1'b0, cur_peak};
   assign rem_next  = fits ? (rem_shift - {1'b0, cur_peak}) : rem_shift;

   always_comb begin
      if (quot_ff < QUOT_W'(F_MIN)) begin
         f_clamped = F_MIN;
      end else if (quot_ff > QUOT_W'(F_MAX)) begin
         f_clamped = F_MAX;
      end else begin
         f_clamped = quot_ff[F_W-1:0];
      end
   end

   assign square = m_ff * m_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quot_ff <= numerator;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[QUOT_W-2:0], fits};
         rem_ff  <= rem_next[SAMPLE_BITS-1:0];
      end
      if (cmd.norm_load) begin
         f_ff     <= f_clamped;
         shift_ff <= '0;
      end else if (cmd.norm_step) begin
         f_ff     <= {f_ff[F_W-2:0], 1'b0};
         shift_ff <= shift_ff + 1'b1;
      end
      if (cmd.log_load) begin
         m_ff    <= {f_ff, {NORM_PAD{1'b0}}};
         frac_ff <= '0;
      end else if (cmd.log_step) begin
         m_ff    <= square[2*M_W-1] ? square[2*M_W-1:M_W] : square[2*M_W-2:M_W-1];
         frac_ff <= {frac_ff[LOG_FRACTION_BITS-2:0], square[2*M_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
         log_cnt_ff <= '0;
      end else begin
         if (cmd.div_load) begin
            div_cnt_ff <= DCNT_W'(QUOT_W);
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (cmd.log_load) begin
            log_cnt_ff <= LCNT_W'(LOG_FRACTION_BITS);
         end else if (cmd.log_step) begin
            log_cnt_ff <= log_cnt_ff - 1'b1;
         end
      end
   end

   assign status.peak_zero = (cur_peak == '0);
   assign status.div_done  = (div_cnt_ff == '0);
   assign status.norm_done = f_ff[F_W-1];
   assign status.log_done  = (log_cnt_ff == '0);
   assign status.two_jobs  = two_jobs_ff;

   // modifier: exponent and fraction, lowest code lifted by one
   assign exp_rel  = EXP_TOP - shift_ff;
   assign frac_adj = (exp_rel == EXP_LOW && frac_ff == '0) ?
                     LOG_FRACTION_BITS'(1) : frac_ff;
   assign res      = {exp_rel, frac_adj};
   assign res_ext  = RES_W'(res);

   assign result.peak_level      = PEAK_OUT_W'(cur_peak);
   assign result.volume_modifier = status.peak_zero ? '0 : res_ext[MOD_W-1:0];
   assign result.has_level       = !status.peak_zero;
   assign result.clip_seen       = cmd.second ? 1'b0 : job1_clip_ff;
   assign result.is_album        = cmd.second;
   assign result.last_result     = cmd.second | !two_jobs_ff;

endmodule

@@ design/peak_level_volume_modifier_core.sv @@
// ----------------------------------------------------------------------------
// peak_level_volume_modifier_core
// Track and album peak meter with a log2 volume modifier per result.
//
// Samples enter on req_ with valid/ready, one per cycle while no result is
// being formed. A sample without req_track_end gives no result. A sample with
// req_track_end gives the track result on rsp_, and with req_album_end also
// the album result after it; rsp_last_result marks the final one.
// Per result the block runs a restoring divider (SAMPLE_BITS+15 quotient
// bits), a leading-one shift of up to 8 places and LOG_FRACTION_BITS
// squaring steps; a zero peak skips straight to the output. req_ready
// stays low while a result is being formed.
// Results sit in an output register; a stalled rsp_ready holds the result
// and the block waits before loading the next one. The csr_ write sets the
// recording gain (Q4.12, zero means 1.0). Reset clears peaks, clip state and
// sets the gain to 1.0.
// ----------------------------------------------------------------------------
module peak_level_volume_modifier_core #(
   parameter int SAMPLE_BITS       = 16,
   parameter int LOG_FRACTION_BITS = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_track_end,
   input  logic                          req_album_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_peak_level,
   output logic [7:0]                    rsp_volume_modifier,
   output logic                          rsp_has_level,
   output logic                          rsp_clip_seen,
   output logic                          rsp_is_album,
   output logic                          rsp_last_result,
   input  logic                          csr_write_enable,
   input  logic [15:0]                   csr_write_data
);
   import plvm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   result_type    result;
   result_type    rsp_data_ff;
   logic          rsp_valid_ff;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   plvm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_track_end (req_track_end),
      .req_ready     (req_ready),
      .out_free      (out_free),
      .status        (status),
      .cmd           (cmd)
   );

   plvm_datapath #(
      .SAMPLE_BITS       (SAMPLE_BITS),
      .LOG_FRACTION_BITS (LOG_FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sample           (req_sample),
      .track_end        (req_track_end),
      .album_end        (req_album_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peak_level      = rsp_data_ff.peak_level;
   assign rsp_volume_modifier = rsp_data_ff.volume_modifier;
   assign rsp_has_level       = rsp_data_ff.has_level;
   assign rsp_clip_seen       = rsp_data_ff.clip_seen;
   assign rsp_is_album        = rsp_data_ff.is_album;
   assign rsp_last_result     = rsp_data_ff.last_result;

endmodule
